// ----- design/osat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osat_pkg: shared types and constants for the box overlap block
// Widths, store row codes, command and micro-op types, small index tables.
// ----------------------------------------------------------------------------
package osat_pkg;

	localparam int COMP_W   = 32;              // vector component width
	localparam int FRAC_W   = 16;              // fraction bits of a component
	localparam int VEC_W    = 3 * COMP_W;
	localparam int NUM_ROWS = 11;
	localparam int ROW_W    = 4;
	localparam int AXIS_W   = 4;
	localparam int LIMB_W   = 32;
	localparam int MA_W     = LIMB_W + 1;      // limb plus sign
	localparam int MB_W     = COMP_W + 3;      // holds a centre difference
	localparam int PROD_W   = MA_W + MB_W;
	// largest sum is six terms of |half| * |axis . L|, below 2^130
	localparam int ACC_W    = 136;

	localparam logic [ROW_W-1:0] ROW_A_CENTRE = 4'd0;
	localparam logic [ROW_W-1:0] ROW_A_AXIS0  = 4'd1;
	localparam logic [ROW_W-1:0] ROW_A_HALF   = 4'd4;
	localparam logic [ROW_W-1:0] ROW_B_CENTRE = 4'd5;
	localparam logic [ROW_W-1:0] ROW_B_AXIS0  = 4'd6;
	localparam logic [ROW_W-1:0] ROW_B_HALF   = 4'd9;
	localparam logic [ROW_W-1:0] ROW_TRANS    = 4'd10;

	localparam logic [AXIS_W-1:0] FIRST_CROSS = 4'd6;
	localparam logic [AXIS_W-1:0] LAST_AXIS   = 4'd14;
	localparam logic [AXIS_W-1:0] NO_AXIS     = 4'd15;

	typedef enum logic {CMD_LOAD, CMD_TEST} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [ROW_W-1:0] slot;
		logic [VEC_W-1:0] vec;  // {z, y, x}
	} cmd_t;

	typedef struct packed {
		logic              collide;
		logic [AXIS_W-1:0] axis;
	} res_t;

	typedef enum logic [2:0] {SQ_IDLE, SQ_RUN, SQ_DRAIN, SQ_ABS, SQ_CMP} seq_state_t;
	typedef enum logic [2:0] {PH_DELTA, PH_AXIS, PH_PROJ, PH_DIST, PH_EXT} phase_t;
	typedef enum logic {MA_MEM, MA_LIMB} ma_sel_t;
	typedef enum logic [1:0] {MB_MEM, MB_ONE, MB_DELTA} mb_sel_t;
	typedef enum logic [2:0] {DST_DL, DST_L, DST_P, DST_LHS, DST_RHS} dst_t;

	typedef struct packed {
		logic             vld;
		logic [ROW_W-1:0] ra;
		logic [1:0]       ca;
		logic [ROW_W-1:0] rb;
		logic [1:0]       cb;
		ma_sel_t          ma_sel;
		mb_sel_t          mb_sel;
		logic             src_p;     // limb source: 1 projection, 0 axis
		logic [2:0]       src_idx;
		logic [1:0]       limb;
		logic             top;       // top limb carries the sign
		logic             first;
		logic             last;
		logic             sub;
		logic             sgn_mode;  // sign from operands, adds a magnitude
		dst_t             dst;
		logic [2:0]       dst_idx;
	} op_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
		logic [VEC_W-1:0] data;
	} wr_t;

	function automatic logic [1:0] inc3(input logic [1:0] c);
		return (c == 2'd2) ? 2'd0 : c + 2'd1;
	endfunction

	function automatic logic [ROW_W-1:0] box_axis_row(input logic [2:0] k);
		return (k < 3'd3) ? ROW_A_AXIS0 + ROW_W'(k) : ROW_B_AXIS0 + ROW_W'(k - 3'd3);
	endfunction

	function automatic logic [1:0] box_comp(input logic [2:0] k);
		logic [2:0] r;
		r = (k < 3'd3) ? k : k - 3'd3;
		return r[1:0];
	endfunction

	function automatic logic [ROW_W-1:0] cross_row_a(input logic [AXIS_W-1:0] n);
		logic [ROW_W-1:0] r;
		case (n) inside
			[4'd6:4'd8]:   r = ROW_A_AXIS0;
			[4'd9:4'd11]:  r = ROW_A_AXIS0 + 4'd1;
			default:       r = ROW_A_AXIS0 + 4'd2;
		endcase
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] cross_row_b(input logic [AXIS_W-1:0] n);
		logic [ROW_W-1:0] r;
		case (n) inside
			4'd6, 4'd9, 4'd12:  r = ROW_B_AXIS0;
			4'd7, 4'd10, 4'd13: r = ROW_B_AXIS0 + 4'd1;
			default:            r = ROW_B_AXIS0 + 4'd2;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/osat_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osat_front: input acceptance and command queue
// Classifies each transaction as load or test, drops loads to a missing slot.
// ----------------------------------------------------------------------------
module osat_front import osat_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     action,
	input  logic [ROW_W-1:0]         slot,
	input  logic signed [COMP_W-1:0] vec_x,
	input  logic signed [COMP_W-1:0] vec_y,
	input  logic signed [COMP_W-1:0] vec_z,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_pop
);

	cmd_t       q_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept, keep;
	cmd_t       entry;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];

	always_comb begin
		accept     = push && !full;
		entry.kind = action ? CMD_TEST : CMD_LOAD;
		entry.slot = slot;
		entry.vec  = {vec_z, vec_y, vec_x};
		keep       = accept && ((entry.kind == CMD_TEST) || (slot inside {[4'd0:ROW_TRANS]}));
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			q_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (keep) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, cmd_pop};
		end
	end

endmodule
`default_nettype wire

// ----- design/osat_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osat_seq: test sequencer
// Walks the axes and issues one multiply-accumulate micro-op per cycle while a phase runs, pausing between phases.
// ----------------------------------------------------------------------------
module osat_seq import osat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res,
	output op_t  op,
	output wr_t  wr,
	output logic abs_en,
	input  logic sep
);

	seq_state_t        state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [AXIS_W-1:0] n_q, n_d;
	logic [2:0]        o_q, o_d;
	logic [1:0]        c_q, c_d;
	logic [1:0]        i_q, i_d;
	logic              drain_q, drain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			phase_q <= PH_DELTA;
			n_q     <= '0;
			o_q     <= '0;
			c_q     <= '0;
			i_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			n_q     <= n_d;
			o_q     <= o_d;
			c_q     <= c_d;
			i_q     <= i_d;
			drain_q <= drain_d;
		end
	end

	always_comb begin
		logic [1:0] imax, cmax;
		logic [2:0] omax;
		logic       is_cross;
		is_cross = (n_q >= FIRST_CROSS);
		op    = '0;
		imax  = 2'd2;
		cmax  = 2'd2;
		omax  = 3'd0;
		case (phase_q)
			PH_DELTA: begin
				op.ra     = (i_q == 2'd0) ? ROW_B_CENTRE :
				            (i_q == 2'd1) ? ROW_A_CENTRE : ROW_TRANS;
				op.ca     = c_q;
				op.ma_sel = MA_MEM;
				op.mb_sel = MB_ONE;
				op.sub    = (i_q != 2'd0);
				op.first  = (i_q == 2'd0);
				op.last   = (i_q == 2'd2);
				op.dst    = DST_DL;
				op.dst_idx = {1'b0, c_q};
			end
			PH_AXIS: begin
				imax      = is_cross ? 2'd1 : 2'd0;
				op.ma_sel = MA_MEM;
				op.first  = (i_q == 2'd0);
				op.last   = (i_q == imax);
				op.dst    = DST_L;
				op.dst_idx = {1'b0, c_q};
				if (is_cross) begin
					// component c of A_i x B_j: two products, second subtracted
					op.ra     = cross_row_a(n_q);
					op.rb     = cross_row_b(n_q);
					op.ca     = (i_q == 2'd0) ? inc3(c_q) : inc3(inc3(c_q));
					op.cb     = (i_q == 2'd0) ? inc3(inc3(c_q)) : inc3(c_q);
					op.mb_sel = MB_MEM;
					op.sub    = (i_q != 2'd0);
				end else begin
					op.ra     = box_axis_row(n_q[2:0]);
					op.ca     = c_q;
					op.mb_sel = MB_ONE;
				end
			end
			PH_PROJ: begin
				omax      = 3'd5;
				op.ma_sel = MA_LIMB;
				op.src_p  = 1'b0;
				op.src_idx = {1'b0, c_q};
				op.limb   = i_q;
				op.top    = (i_q == 2'd2);
				op.mb_sel = MB_MEM;
				op.rb     = box_axis_row(o_q);
				op.cb     = c_q;
				op.first  = (c_q == 2'd0) && (i_q == 2'd0);
				op.last   = (c_q == 2'd2) && (i_q == 2'd2);
				op.dst    = DST_P;
				op.dst_idx = o_q;
			end
			PH_DIST: begin
				op.ma_sel = MA_LIMB;
				op.src_p  = 1'b0;
				op.src_idx = {1'b0, c_q};
				op.limb   = i_q;
				op.top    = (i_q == 2'd2);
				op.mb_sel = MB_DELTA;
				op.first  = (c_q == 2'd0) && (i_q == 2'd0);
				op.last   = (c_q == 2'd2) && (i_q == 2'd2);
				op.dst    = DST_LHS;
			end
			PH_EXT: begin
				imax      = 2'd3;
				cmax      = 2'd0;
				omax      = 3'd5;
				op.ma_sel = MA_LIMB;
				op.src_p  = 1'b1;
				op.src_idx = o_q;
				op.limb   = i_q;
				op.top    = (i_q == 2'd3);
				op.mb_sel = MB_MEM;
				op.rb     = (o_q < 3'd3) ? ROW_A_HALF : ROW_B_HALF;
				op.cb     = box_comp(o_q);
				op.sgn_mode = 1'b1;
				op.first  = (o_q == 3'd0) && (i_q == 2'd0);
				op.last   = (o_q == 3'd5) && (i_q == 2'd3);
				op.dst    = DST_RHS;
			end
			default: begin
				op = '0;
			end
		endcase
		op.vld = (state_q == SQ_RUN);

		state_d  = state_q;
		phase_d  = phase_q;
		n_d      = n_q;
		o_d      = o_q;
		c_d      = c_q;
		i_d      = i_q;
		drain_d  = drain_q;
		cmd_pop  = 1'b0;
		wr       = '0;
		abs_en   = 1'b0;
		res_push = 1'b0;
		res.collide = 1'b0;
		res.axis    = n_q;

		case (state_q)
			SQ_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_LOAD) begin
						cmd_pop = 1'b1;
						wr.en   = 1'b1;
						wr.row  = cmd.slot;
						wr.data = cmd.vec;
					end else if (!res_full) begin
						cmd_pop = 1'b1;
						state_d = SQ_RUN;
						phase_d = PH_DELTA;
						n_d     = '0;
						o_d     = '0;
						c_d     = '0;
						i_d     = '0;
					end
				end
			end
			SQ_RUN: begin
				if (i_q == imax) begin
					i_d = '0;
					if (c_q == cmax) begin
						c_d = '0;
						if (o_q == omax) begin
							o_d     = '0;
							state_d = SQ_DRAIN;
							drain_d = 1'b0;
						end else begin
							o_d = o_q + 3'd1;
						end
					end else begin
						c_d = c_q + 2'd1;
					end
				end else begin
					i_d = i_q + 2'd1;
				end
			end
			SQ_DRAIN: begin
				// let the last op clear the multiply and add stages
				drain_d = 1'b1;
				if (drain_q) begin
					state_d = SQ_RUN;
					case (phase_q)
						PH_DELTA: phase_d = PH_AXIS;
						PH_AXIS:  phase_d = PH_PROJ;
						PH_PROJ:  phase_d = PH_DIST;
						PH_DIST:  phase_d = PH_EXT;
						default:  state_d = SQ_ABS;
					endcase
				end
			end
			SQ_ABS: begin
				abs_en  = 1'b1;
				state_d = SQ_CMP;
			end
			SQ_CMP: begin
				if (sep) begin
					res_push = 1'b1;
					state_d  = SQ_IDLE;
				end else if (n_q == LAST_AXIS) begin
					res_push    = 1'b1;
					res.collide = 1'b1;
					res.axis    = NO_AXIS;
					state_d     = SQ_IDLE;
				end else begin
					n_d     = n_q + 4'd1;
					phase_d = PH_AXIS;
					state_d = SQ_RUN;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/osat_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osat_dp: vector store and multiply-accumulate datapath
// Store read, one limb multiply, shifted add into the running sum.
// ----------------------------------------------------------------------------
module osat_dp import osat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  op_t  op,
	input  wr_t  wr,
	input  logic abs_en,
	output logic sep
);

	logic [VEC_W-1:0]  mem [NUM_ROWS];
	logic [VEC_W-1:0]  rda_s1, rdb_s1;
	op_t               op_s1, op_s2;
	logic              sub_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] run_q;
	logic signed [ACC_W-1:0] l_q  [3];
	logic signed [ACC_W-1:0] p_q  [6];
	logic signed [ACC_W-1:0] dl_q [3];
	logic signed [ACC_W-1:0] lhs_q, rhs_q;
	logic [ACC_W-1:0]        lhs_abs_q;

	logic [COMP_W-1:0]       comp_a, comp_b;
	logic signed [ACC_W-1:0] srcv;
	logic [LIMB_W-1:0]       limb;
	logic signed [MA_W-1:0]  ma;
	logic signed [MB_W-1:0]  mb;
	logic                    sub_s1;
	logic signed [ACC_W-1:0] addend, base, sum;

	// store: one row write, two registered row reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.data;
		end
		rda_s1 <= mem[op.ra];
		rdb_s1 <= mem[op.rb];
	end

	always_comb begin
		comp_a = rda_s1[op_s1.ca * COMP_W +: COMP_W];
		comp_b = rdb_s1[op_s1.cb * COMP_W +: COMP_W];
		srcv   = op_s1.src_p ? p_q[op_s1.src_idx] : l_q[op_s1.src_idx[1:0]];
		limb   = srcv[op_s1.limb * LIMB_W +: LIMB_W];
		if (op_s1.ma_sel == MA_MEM) begin
			ma = MA_W'(signed'(comp_a));
		end else begin
			ma = {op_s1.top & limb[LIMB_W-1], limb};
		end
		case (op_s1.mb_sel)
			MB_MEM:   mb = MB_W'(signed'(comp_b));
			MB_ONE:   mb = MB_W'(1);
			MB_DELTA: mb = dl_q[op_s1.src_idx[1:0]][MB_W-1:0];
			default:  mb = '0;
		endcase
		// magnitude mode: subtract when the operand signs differ
		sub_s1 = op_s1.sgn_mode ? (srcv[ACC_W-1] ^ comp_b[COMP_W-1]) : op_s1.sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
		end else begin
			op_s1 <= op;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ma * mb;
		sub_s2  <= sub_s1;
	end

	always_comb begin
		addend = ACC_W'(prod_s2) <<< (op_s2.limb * LIMB_W);
		base   = op_s2.first ? '0 : run_q;
		sum    = sub_s2 ? base - addend : base + addend;
		sep    = (lhs_abs_q << FRAC_W) > rhs_q;
	end

	always_ff @(posedge clk) begin
		if (op_s2.vld) begin
			run_q <= sum;
			if (op_s2.last) begin
				case (op_s2.dst)
					DST_DL:  dl_q[op_s2.dst_idx[1:0]] <= sum;
					DST_L:   l_q[op_s2.dst_idx[1:0]]  <= sum;
					DST_P:   p_q[op_s2.dst_idx]       <= sum;
					DST_LHS: lhs_q <= sum;
					DST_RHS: rhs_q <= sum;
					default: begin
					end
				endcase
			end
		end
		if (abs_en) begin
			lhs_abs_q <= lhs_q[ACC_W-1] ? -lhs_q : lhs_q;
		end
	end

endmodule
`default_nettype wire

// ----- design/osat_res_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osat_res_fifo: two-entry result queue
// Holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module osat_res_fifo import osat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output res_t dout
);

	res_t       q_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign dout    = q_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

// ----- design/obb_separating_axis_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obb_separating_axis_test: oriented box overlap by separating axis test
// Loads box vectors into a store and tests the two boxes for overlap.
// ----------------------------------------------------------------------------
// Input channel: push/full. A transaction with action 0 loads vec_x/y/z into
// slot 0..10 (slots 11..15 are taken and ignored); action 1 runs a test and
// yields one result. Loads yield nothing.
// Result channel: empty/pop. collide and separating_axis show the oldest
// result while empty is low; 15 means no axis separates.
// The back end handles one transaction at a time. A test stops at the first
// separating axis and otherwise walks all 15 axes. Its length is set by the
// single 33x35-bit multiplier, which forms every product one 32-bit limb per
// cycle, plus a drain between phases.
// A two-entry command queue lets loads and tests queue up while a test runs;
// a two-entry result queue lets the back end finish while the receiver
// stalls. A test starts only when the result queue has room.
// Reset clears both queues and the sequencer; the store holds garbage until
// each slot is loaded, and every slot must be loaded before a test.
// ----------------------------------------------------------------------------
module obb_separating_axis_test import osat_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     action,
	input  logic [ROW_W-1:0]         slot,
	input  logic signed [COMP_W-1:0] vec_x,
	input  logic signed [COMP_W-1:0] vec_y,
	input  logic signed [COMP_W-1:0] vec_z,
	output logic                     empty,
	input  logic                     pop,
	output logic                     collide,
	output logic [AXIS_W-1:0]        separating_axis
);

	// front to back command hand-off
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	// sequencer to datapath
	op_t  op;
	wr_t  wr;
	logic abs_en, sep;

	// result queue
	logic res_push, res_full;
	res_t res, res_out;

	osat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.slot      (slot),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Advance through delta, axis, projection, distance and extent phases.
	osat_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res),
		.op        (op),
		.wr        (wr),
		.abs_en    (abs_en),
		.sep       (sep)
	);

	// Hold the store, multiply, and accumulate exact wide sums.
	osat_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.wr     (wr),
		.abs_en (abs_en),
		.sep    (sep)
	);

	osat_res_fifo u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_out)
	);

	assign collide         = res_out.collide;
	assign separating_axis = res_out.axis;

endmodule
`default_nettype wire

// ----- design/osat_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osat_checker: port-level checks for the box overlap block
// Result consistency and result channel stability.
// ----------------------------------------------------------------------------
module osat_checker import osat_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic              collide,
	input logic [AXIS_W-1:0] separating_axis
);

	a_collide_none: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && collide) |-> (separating_axis == NO_AXIS))
		else $error("collide result names a separating axis");

	a_sep_named: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !collide) |-> (separating_axis != NO_AXIS))
		else $error("separated result has no axis");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(collide) && $stable(separating_axis)))
		else $error("waiting result changed or vanished");

endmodule

bind obb_separating_axis_test osat_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.collide         (collide),
	.separating_axis (separating_axis)
);
`default_nettype wire

// ----- tb/obb_separating_axis_test_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_separating_axis_test_tb: self-checking bench for the box overlap block
// Loads box vectors, runs overlap tests and checks every result against an
// exact wide-integer separating axis predictor. Both channels idle at random.
// ----------------------------------------------------------------------------
module obb_separating_axis_test_tb import osat_pkg::*;;

	// wide enough for every product and sum of the test without rounding
	typedef logic signed [199:0] wint_t;

	typedef struct {
		cmd_kind_t               kind;
		logic [ROW_W-1:0]        slot;
		logic signed [COMP_W-1:0] x, y, z;
	} box_cmd_t;

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic                     action;
	logic [ROW_W-1:0]         slot;
	logic signed [COMP_W-1:0] vec_x, vec_y, vec_z;
	logic                     empty;
	logic                     pop;
	logic                     collide;
	logic [AXIS_W-1:0]        separating_axis;

	box_cmd_t            cmd_q[$];          // transactions still to offer
	box_cmd_t            cur_cmd;           // transaction now on the input ports
	logic [AXIS_W-1:0]   axis_expect_q[$];  // predicted first separating axis
	logic signed [COMP_W-1:0] box_store[3*NUM_ROWS];
	int                  errors = 0;
	int                  results_seen = 0;
	int                  burst_left = 0;
	int                  gap_left = 0;
	int                  cycle_cnt = 0;
	logic                hold_off = 1'b0;
	logic                stim_done = 1'b0;

	obb_separating_axis_test u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.slot(slot), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.empty(empty), .pop(pop), .collide(collide),
		.separating_axis(separating_axis)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------------
	// Predictor: exact separating axis test on the mirrored store.
	// ------------------------------------------------------------------------
	function automatic wint_t comp_of(input int row, input int c);
		return wint_t'(box_store[row*3 + c]);
	endfunction

	function automatic wint_t abs_w(input wint_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [AXIS_W-1:0] first_separating_axis();
		wint_t ax[6][3];
		wint_t ext[6][3];
		wint_t delta[3];
		wint_t lax[3];
		wint_t lhs, rhs, proj;
		int    a, b;
		for (int k = 0; k < 6; k++) begin
			for (int c = 0; c < 3; c++) begin
				ax[k][c] = (k < 3) ? comp_of(ROW_A_AXIS0 + k, c)
				                   : comp_of(ROW_B_AXIS0 + k - 3, c);
				ext[k][c] = ax[k][c] * ((k < 3) ? comp_of(ROW_A_HALF, k)
				                                : comp_of(ROW_B_HALF, k - 3));
			end
		end
		// bring the centre offset to the scale of the extent products
		for (int c = 0; c < 3; c++)
			delta[c] = (comp_of(ROW_B_CENTRE, c)
			           - (comp_of(ROW_A_CENTRE, c) + comp_of(ROW_TRANS, c))) <<< FRAC_W;
		for (int n = 0; n <= LAST_AXIS; n++) begin
			if (n < FIRST_CROSS) begin
				lax = ax[n];
			end else begin
				a = (n - FIRST_CROSS) / 3;
				b = 3 + (n - FIRST_CROSS) % 3;
				lax[0] = ax[a][1]*ax[b][2] - ax[a][2]*ax[b][1];
				lax[1] = ax[a][2]*ax[b][0] - ax[a][0]*ax[b][2];
				lax[2] = ax[a][0]*ax[b][1] - ax[a][1]*ax[b][0];
			end
			lhs = abs_w(delta[0]*lax[0] + delta[1]*lax[1] + delta[2]*lax[2]);
			rhs = '0;
			for (int k = 0; k < 6; k++) begin
				proj = ext[k][0]*lax[0] + ext[k][1]*lax[1] + ext[k][2]*lax[2];
				rhs += abs_w(proj);
			end
			if (lhs > rhs)
				return AXIS_W'(n);
		end
		return NO_AXIS;
	endfunction

	function automatic void add_item(input box_cmd_t t);
		cmd_q.insert(cmd_q.size(), t);
	endfunction

	function automatic void apply_cmd(input box_cmd_t t);
		if (t.kind == CMD_TEST) begin
			axis_expect_q.insert(axis_expect_q.size(), first_separating_axis());
		end else if (t.slot < NUM_ROWS) begin
			box_store[t.slot*3 + 0] = t.x;
			box_store[t.slot*3 + 1] = t.y;
			box_store[t.slot*3 + 2] = t.z;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic signed [COMP_W-1:0] rand_comp(input logic [ROW_W-1:0] row);
		logic signed [COMP_W-1:0] v;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			v = $urandom;
		end else if (mode < 3) begin
			case ($urandom_range(0, 4))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7FFF_FFFF;
				2: v = 0;
				3: v = 32'sh0001_0000;
				default: v = -32'sh0001_0000;
			endcase
		end else if (row == ROW_A_HALF || row == ROW_B_HALF) begin
			// positive sizes large enough that boxes often overlap
			v = $urandom_range(0, 1 << 20);
		end else if (row == ROW_A_CENTRE || row == ROW_B_CENTRE || row == ROW_TRANS) begin
			v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		end else begin
			v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		end
		return v;
	endfunction

	function automatic box_cmd_t load_cmd(input logic [ROW_W-1:0] row,
	                                      input int x, input int y, input int z);
		box_cmd_t t;
		t.kind = CMD_LOAD;
		t.slot = row;
		t.x = x;
		t.y = y;
		t.z = z;
		return t;
	endfunction

	function automatic box_cmd_t test_cmd();
		box_cmd_t t;
		t.kind = CMD_TEST;
		t.slot = ROW_W'($urandom);
		t.x = $urandom;
		t.y = $urandom;
		t.z = $urandom;
		return t;
	endfunction

	// ------------------------------------------------------------------------
	// Build the item list: directed part first, then random sequences.
	// ------------------------------------------------------------------------
	initial begin
		logic [ROW_W-1:0] row;
		int n_loads;
		int one;
		one = 32'sh0001_0000;
		// two unit boxes, same orientation, overlapping
		add_item(load_cmd(ROW_A_CENTRE, 0, 0, 0));
		add_item(load_cmd(ROW_A_AXIS0,     one, 0, 0));
		add_item(load_cmd(ROW_A_AXIS0 + 1, 0, one, 0));
		add_item(load_cmd(ROW_A_AXIS0 + 2, 0, 0, one));
		add_item(load_cmd(ROW_A_HALF, one, one, one));
		add_item(load_cmd(ROW_B_CENTRE, one, 0, 0));
		add_item(load_cmd(ROW_B_AXIS0,     one, 0, 0));
		add_item(load_cmd(ROW_B_AXIS0 + 1, 0, one, 0));
		add_item(load_cmd(ROW_B_AXIS0 + 2, 0, 0, one));
		add_item(load_cmd(ROW_B_HALF, one, one, one));
		add_item(load_cmd(ROW_TRANS, 0, 0, 0));
		add_item(test_cmd());          // parallel axes: degenerate crosses
		// touching exactly is not separation; just past it is
		add_item(load_cmd(ROW_B_CENTRE, 2*one, 0, 0));
		add_item(test_cmd());
		add_item(load_cmd(ROW_TRANS, -1, 0, 0));
		add_item(test_cmd());
		// out-of-range slot writes nothing
		add_item(load_cmd(4'd11, 32'h7FFF_FFFF, 0, 0));
		add_item(load_cmd(4'd15, -1, -1, -1));
		add_item(test_cmd());
		// extremes of every component
		add_item(load_cmd(ROW_B_CENTRE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_item(load_cmd(ROW_A_CENTRE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		add_item(load_cmd(ROW_TRANS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		add_item(load_cmd(ROW_A_HALF, 32'h7FFF_FFFF, 32'h8000_0000, -1));
		add_item(load_cmd(ROW_B_AXIS0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		add_item(test_cmd());

		// random part: a few loads with random content, then a test
		while (cmd_q.size() < 1150) begin
			n_loads = $urandom_range(0, 4);
			for (int i = 0; i < n_loads; i++) begin
				row = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
				                                   : 4'($urandom_range(0, 10));
				add_item(load_cmd(row, rand_comp(row), rand_comp(row), rand_comp(row)));
			end
			add_item(test_cmd());
		end
		stim_done = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Reset and driver: offer items in bursts with random gaps.
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		push = 1'b0;
		action = 1'b0;
		slot = '0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		pop = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && full) begin
			// hold the offered transaction until the block takes it
		end else begin
			if (push) begin
				apply_cmd(cur_cmd);
				void'(cmd_q.pop_front());
			end
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				cur_cmd = cmd_q[0];
				push   <= 1'b1;
				action <= cur_cmd.kind;
				slot   <= cur_cmd.slot;
				vec_x  <= cur_cmd.x;
				vec_y  <= cur_cmd.y;
				vec_z  <= cur_cmd.z;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver hold-off: one long stall so the block fills and pushes back.
	// ------------------------------------------------------------------------
	initial begin
		wait (results_seen >= 20);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (4000) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: take results on its own stall pattern and check them.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic [AXIS_W-1:0] exp_axis;
		cycle_cnt++;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (axis_expect_q.size() == 0) begin
				$display("%0t: unexpected result collide=%0b axis=%0d",
				         $time, collide, separating_axis);
				errors++;
			end else begin
				exp_axis = axis_expect_q.pop_front();
				if (collide !== (exp_axis == NO_AXIS)) begin
					$display("%0t: collide expected %0b actual %0b",
					         $time, exp_axis == NO_AXIS, collide);
					errors++;
				end
				if (separating_axis !== exp_axis) begin
					$display("%0t: separating_axis expected %0d actual %0d",
					         $time, exp_axis, separating_axis);
					errors++;
				end
			end
		end
		// drain freely for a stretch, then stall at random
		if (!arst_n || hold_off)
			pop <= 1'b0;
		else if (cycle_cnt % 1024 < 300)
			pop <= 1'b1;
		else
			pop <= ($urandom_range(0, 3) != 0);
	end

	// ------------------------------------------------------------------------
	// End of run
	// ------------------------------------------------------------------------
	initial begin
		wait (stim_done);
		wait (cmd_q.size() == 0 && !push);
		wait (axis_expect_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && axis_expect_q.size() == 0)
			$display("** obb_separating_axis_test: PASSED **");
		else
			$display("** obb_separating_axis_test: FAILED **");
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout");
		$display("** obb_separating_axis_test: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
design/osat_pkg.sv
design/osat_front.sv
design/osat_seq.sv
design/osat_dp.sv
design/osat_res_fifo.sv
design/obb_separating_axis_test.sv
design/osat_checker.sv
tb/obb_separating_axis_test_tb.sv
